// ----- hw/rtl/bdss_pkg.sv -----
// Shared types, codes and helper functions for the bounded deque with search and sort.
// Used by bdss_ctrl, bdss_dp, the top level and bdss_checker; depends on nothing.
`timescale 1ns / 1ps

package bdss_pkg;

    localparam int NameW  = 152;
    localparam int PriceW = 16;
    localparam int TotalW = 20;
    localparam int CountW = 5;
    localparam int InDataW  = 168;
    localparam int OutDataW = 200;

    // Request kinds.
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_FIND_NAME  = 3'd4;
    localparam logic [2:0] REQ_FIND_PRICE = 3'd5;
    localparam logic [2:0] REQ_SORT       = 3'd6;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_TOO_FEW   = 3'd4;

    typedef struct packed {
        logic [PriceW-1:0] price;
        logic [NameW-1:0]  name;
    } rec_t;

    typedef enum logic [1:0] {RD_I, RD_J, RD_POP_FRONT, RD_POP_BACK} rd_sel_t;
    typedef enum logic [1:0] {WR_PUSH, WR_J, WR_I} wr_sel_t;
    typedef enum logic [1:0] {SRC_NONE, SRC_Q, SRC_A, SRC_RD} out_src_t;

    typedef struct packed {
        logic     capture;
        logic     push;
        logic     pop_take;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     a_load_rd;
        logic     i_clr;
        logic     i_inc;
        logic     j_init;
        logic     j_inc;
        logic     out_load;
        out_src_t out_src;
        logic [2:0] out_status;
        logic     out_last;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       full;
        logic       empty;
        logic       few;
        logic       hit;
        logic       swap;
        logic       find_more;
        logic       j_more;
        logic       i_more;
        logic       out_last;
        logic       out_free;
    } stat_t;

    // Clears every byte after the first zero byte of the name.
    function automatic logic [NameW-1:0] canon_name(logic [NameW-1:0] name);
        logic             alive;
        logic [NameW-1:0] res;
        alive = 1'b1;
        res   = '0;
        for (int k = 0; k < NameW / 8; k++)
        begin
            if (alive)
            begin
                res[k*8 +: 8] = name[k*8 +: 8];
            end
            if (name[k*8 +: 8] == 8'h00)
            begin
                alive = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/bounded_deque_search_sort.sv -----
// Bounded double-ended record list with find and exchange sort, one request at a time.
// A find reads each held record in turn; a sort takes each outer position, compares it with
// every later record, then reads every record out in order. The record memory has one
// read and one write port. A new request is taken only once the previous one has handed
// its last result, if any, to the output register. Reset (rst_n low, asynchronous)
// empties the list and clears count and total; record memory is not cleared, since only
// held records are ever read.
`timescale 1ns / 1ps

// Top level: joins the controller and the datapath.
// Depends on bdss_pkg, bdss_ctrl and bdss_dp.
module bounded_deque_search_sort #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // item_price[167:152], name_bytes_high[151:128], name_bytes_mid[127:64],
    // name_bytes_low[63:0]
    input  logic [167:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // zero pad[199:193], price_total[192:173], record_count[172:168], out_price[167:152],
    // out_name_high[151:128], out_name_mid[127:64], out_name_low[63:0]
    output logic [199:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]  m_axis_tuser,
    // last_of_run: marks the final result item of a request
    output logic        m_axis_tlast
);

    // The controller only sequences; all state that the list needs lives in the datapath.
    bdss_pkg::cmd_t  cmd;
    bdss_pkg::stat_t stat;

    bdss_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // The datapath holds the result register, so the next step of a find or a sort goes on
    // while a finished result item waits for the downstream side.
    bdss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- hw/rtl/bdss_ctrl.sv -----
// Controller state machine for the bounded deque: sequences requests as datapath commands.
// Depends on bdss_pkg.
`timescale 1ns / 1ps

module bdss_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  bdss_pkg::stat_t stat,
    output bdss_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_PUSH, S_POP_TAKE, S_EMIT_Q, S_EMIT_A, S_EMIT_ERR,
        S_FIND_RD, S_FIND_CHK, S_FIND_END, S_SORT_RDI, S_SORT_TAKEI, S_SORT_RDJ,
        S_SORT_CMP, S_SORT_WRI, S_OUT_RD, S_OUT_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] err_reg, err_next;
    logic       pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            err_reg   <= bdss_pkg::ST_OK;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        err_next      = err_reg;
        pend_next     = pend_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                pend_next = 1'b0;
                case (stat.req)
                    bdss_pkg::REQ_PUSH_FRONT, bdss_pkg::REQ_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            err_next   = bdss_pkg::ST_FULL;
                            state_next = S_EMIT_ERR;
                        end
                        else
                        begin
                            state_next = S_PUSH;
                        end
                    end
                    bdss_pkg::REQ_POP_FRONT, bdss_pkg::REQ_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            err_next   = bdss_pkg::ST_EMPTY;
                            state_next = S_EMIT_ERR;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = (stat.req == bdss_pkg::REQ_POP_FRONT) ?
                                         bdss_pkg::RD_POP_FRONT : bdss_pkg::RD_POP_BACK;
                            state_next = S_POP_TAKE;
                        end
                    end
                    bdss_pkg::REQ_FIND_NAME, bdss_pkg::REQ_FIND_PRICE:
                    begin
                        if (stat.empty)
                        begin
                            err_next   = bdss_pkg::ST_NOT_FOUND;
                            state_next = S_EMIT_ERR;
                        end
                        else
                        begin
                            cmd.i_clr  = 1'b1;
                            state_next = S_FIND_RD;
                        end
                    end
                    bdss_pkg::REQ_SORT:
                    begin
                        if (stat.few)
                        begin
                            err_next   = bdss_pkg::ST_TOO_FEW;
                            state_next = S_EMIT_ERR;
                        end
                        else
                        begin
                            cmd.i_clr  = 1'b1;
                            state_next = S_SORT_RDI;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PUSH:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bdss_pkg::WR_PUSH;
                cmd.push   = 1'b1;
                state_next = S_EMIT_Q;
            end
            S_POP_TAKE:
            begin
                cmd.pop_take = 1'b1;
                state_next   = S_EMIT_A;
            end
            S_EMIT_Q, S_EMIT_A, S_EMIT_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = (state_reg == S_EMIT_ERR) ? err_reg : bdss_pkg::ST_OK;
                    cmd.out_src    = (state_reg == S_EMIT_Q) ? bdss_pkg::SRC_Q :
                                     (state_reg == S_EMIT_A) ? bdss_pkg::SRC_A :
                                     bdss_pkg::SRC_NONE;
                    state_next     = S_IDLE;
                end
            end
            S_FIND_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bdss_pkg::RD_I;
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                // A new match pushes the previous one out, which needs a free output register.
                if (!(stat.hit && pend_reg && !stat.out_free))
                begin
                    if (stat.hit)
                    begin
                        cmd.a_load_rd = 1'b1;
                        pend_next     = 1'b1;
                        if (pend_reg)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_src    = bdss_pkg::SRC_A;
                            cmd.out_status = bdss_pkg::ST_OK;
                        end
                    end
                    cmd.i_inc  = 1'b1;
                    state_next = stat.find_more ? S_FIND_RD : S_FIND_END;
                end
            end
            S_FIND_END:
            begin
                if (pend_reg)
                begin
                    state_next = S_EMIT_A;
                end
                else
                begin
                    err_next   = bdss_pkg::ST_NOT_FOUND;
                    state_next = S_EMIT_ERR;
                end
            end
            S_SORT_RDI:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bdss_pkg::RD_I;
                state_next = S_SORT_TAKEI;
            end
            S_SORT_TAKEI:
            begin
                cmd.a_load_rd = 1'b1;
                cmd.j_init    = 1'b1;
                state_next    = S_SORT_RDJ;
            end
            S_SORT_RDJ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bdss_pkg::RD_J;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                if (stat.swap)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.wr_sel    = bdss_pkg::WR_J;
                    cmd.a_load_rd = 1'b1;
                end
                cmd.j_inc  = 1'b1;
                state_next = stat.j_more ? S_SORT_RDJ : S_SORT_WRI;
            end
            S_SORT_WRI:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bdss_pkg::WR_I;
                if (stat.i_more)
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_SORT_RDI;
                end
                else
                begin
                    cmd.i_clr  = 1'b1;
                    state_next = S_OUT_RD;
                end
            end
            S_OUT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = bdss_pkg::RD_I;
                state_next = S_OUT_EMIT;
            end
            S_OUT_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_src    = bdss_pkg::SRC_RD;
                    cmd.out_status = bdss_pkg::ST_OK;
                    cmd.out_last   = stat.out_last;
                    cmd.i_inc      = 1'b1;
                    state_next     = stat.out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/bdss_dp.sv -----
// Datapath of the bounded deque: record memory, pointers, counters and the result register.
// Depends on bdss_pkg; driven by bdss_ctrl commands.
`timescale 1ns / 1ps

module bdss_dp #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bdss_pkg::InDataW-1:0]      s_axis_tdata,
    input  logic [2:0]                        s_axis_tuser,
    input  bdss_pkg::cmd_t                    cmd,
    output bdss_pkg::stat_t                   stat,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bdss_pkg::OutDataW-1:0]     m_axis_tdata,
    output logic [2:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int IW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bdss_pkg::rec_t mem [DEPTH];

    bdss_pkg::rec_t q_reg, a_reg, rd_data_reg, out_rec_reg;
    logic [2:0]     req_reg;
    logic [IW-1:0]  front_reg;
    logic [CW-1:0]  count_reg, i_reg, j_reg;
    logic [bdss_pkg::TotalW-1:0] total_reg, out_total_reg;
    logic [CW-1:0]  out_count_reg;
    logic [2:0]     out_status_reg;
    logic           out_last_reg, out_valid_reg;

    logic [IW-1:0]  rd_addr, wr_addr, front_dec, front_inc;
    bdss_pkg::rec_t wr_data, out_src_rec;
    logic [8:0]     count_ext;

    function automatic logic [IW-1:0] slot_of(logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(front_reg) + (CW+1)'(pos);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    always_comb
    begin
        case (cmd.rd_sel)
            bdss_pkg::RD_I:         rd_addr = slot_of(i_reg);
            bdss_pkg::RD_J:         rd_addr = slot_of(j_reg);
            bdss_pkg::RD_POP_FRONT: rd_addr = front_reg;
            bdss_pkg::RD_POP_BACK:  rd_addr = slot_of(count_reg - 1'b1);
            default:                rd_addr = front_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            bdss_pkg::WR_PUSH:
            begin
                wr_addr = (req_reg == bdss_pkg::REQ_PUSH_FRONT) ? front_dec : slot_of(count_reg);
                wr_data = q_reg;
            end
            bdss_pkg::WR_J:
            begin
                wr_addr = slot_of(j_reg);
                wr_data = a_reg;
            end
            default:
            begin
                wr_addr = slot_of(i_reg);
                wr_data = a_reg;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.out_src)
            bdss_pkg::SRC_Q:  out_src_rec = q_reg;
            bdss_pkg::SRC_A:  out_src_rec = a_reg;
            bdss_pkg::SRC_RD: out_src_rec = rd_data_reg;
            default:          out_src_rec = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg       <= s_axis_tuser;
            q_reg.name    <= bdss_pkg::canon_name(s_axis_tdata[bdss_pkg::NameW-1:0]);
            q_reg.price   <= s_axis_tdata[bdss_pkg::InDataW-1:bdss_pkg::NameW];
        end
        if (cmd.a_load_rd || cmd.pop_take)
        begin
            a_reg <= rd_data_reg;
        end
        if (cmd.i_clr)
        begin
            i_reg <= '0;
        end
        else if (cmd.i_inc)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.j_init)
        begin
            j_reg <= i_reg + 1'b1;
        end
        else if (cmd.j_inc)
        begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_rec_reg    <= out_src_rec;
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
            out_count_reg  <= count_reg;
            out_total_reg  <= total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                count_reg <= count_reg + 1'b1;
                total_reg <= total_reg + bdss_pkg::TotalW'(q_reg.price);
                if (req_reg == bdss_pkg::REQ_PUSH_FRONT)
                begin
                    front_reg <= front_dec;
                end
            end
            else if (cmd.pop_take)
            begin
                count_reg <= count_reg - 1'b1;
                total_reg <= total_reg - bdss_pkg::TotalW'(rd_data_reg.price);
                if (req_reg == bdss_pkg::REQ_POP_FRONT)
                begin
                    front_reg <= front_inc;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.req       = req_reg;
        stat.full      = (count_reg == CW'(DEPTH));
        stat.empty     = (count_reg == '0);
        stat.few       = (count_reg < CW'(2));
        stat.hit       = (req_reg == bdss_pkg::REQ_FIND_NAME) ?
                         (rd_data_reg.name == q_reg.name) :
                         (rd_data_reg.price == q_reg.price);
        stat.swap      = (a_reg.price > rd_data_reg.price);
        stat.find_more = ((CW+1)'(i_reg) + 1'b1) < (CW+1)'(count_reg);
        stat.j_more    = ((CW+1)'(j_reg) + 1'b1) < (CW+1)'(count_reg);
        stat.i_more    = ((CW+1)'(i_reg) + (CW+1)'(2)) < (CW+1)'(count_reg);
        stat.out_last  = ((CW+1)'(i_reg) + 1'b1) == (CW+1)'(count_reg);
        stat.out_free  = !out_valid_reg || m_axis_tready;
    end

    assign count_ext     = 9'(out_count_reg);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'b0, out_total_reg, count_ext[4:0], out_rec_reg.price,
                            out_rec_reg.name};

endmodule

// ----- hw/rtl/bdss_checker.sv -----
// Port-level checks for bounded_deque_search_sort and the bind that attaches them.
// Depends on bdss_pkg.
`timescale 1ns / 1ps

module bdss_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [199:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // A result item waiting downstream is held unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result item changed while stalled");

    // Requests are taken one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while one is in progress");

    // Every failure result stands alone, with no record attached.
    a_fail_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != bdss_pkg::ST_OK |->
            m_axis_tlast && m_axis_tdata[167:0] == '0)
        else $error("failure result not last or carries a record");

    // Popping reports empty only when nothing is held.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == bdss_pkg::ST_EMPTY |->
            m_axis_tdata[172:168] == 5'd0 && m_axis_tdata[192:173] == 20'd0)
        else $error("empty result with records held");

endmodule

bind bounded_deque_search_sort bdss_checker u_bdss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/tb_bounded_deque_search_sort.sv -----
// Self-checking testbench for bounded_deque_search_sort: a directed table, then random requests.
// Depends on bdss_pkg and the block's RTL; holds its own predictor of the record list.
`timescale 1ns / 1ps

module tb_bounded_deque_search_sort;

    localparam int Depth = 16;
    localparam int Latency = 400;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // One expected result item.
    typedef struct {
        logic [2:0]                  status;
        logic [bdss_pkg::NameW-1:0]  name;
        logic [bdss_pkg::PriceW-1:0] price;
        logic [bdss_pkg::CountW-1:0] count;
        logic [bdss_pkg::TotalW-1:0] total;
        logic                        last;
    } outcome_t;

    // One row of the directed table; the status is typed in where it is obvious.
    typedef struct {
        logic [2:0]                  req;
        logic [bdss_pkg::NameW-1:0]  name;
        logic [bdss_pkg::PriceW-1:0] price;
        bit                          fixed;
        logic [2:0]                  status;
    } row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic [2:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [199:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic m_axis_tlast;

    // The predicted list, held in list order from the front.
    logic [bdss_pkg::NameW-1:0]  list_name [Depth];
    logic [bdss_pkg::PriceW-1:0] list_price [Depth];
    int                          held;
    logic [bdss_pkg::TotalW-1:0] price_sum;

    outcome_t                    pending_results [$];
    row_t                        table_rows [$];
    logic [bdss_pkg::NameW-1:0]  name_pool [6];
    logic [bdss_pkg::PriceW-1:0] price_pool [5];
    int                          errors;
    bit                          no_idle;

    bounded_deque_search_sort #(.DEPTH(Depth)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clears every byte after the first zero byte, as the block does on entry.
    function automatic logic [bdss_pkg::NameW-1:0] trim_name(logic [bdss_pkg::NameW-1:0] raw);
        logic [bdss_pkg::NameW-1:0] res;
        bit                         ended;
        res   = '0;
        ended = 1'b0;
        for (int k = 0; k < bdss_pkg::NameW / 8; k++)
        begin
            if (!ended)
            begin
                res[k*8 +: 8] = raw[k*8 +: 8];
                if (raw[k*8 +: 8] == 8'h00)
                begin
                    ended = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // A 19-byte name of random length; bytes past the terminator are sometimes junk.
    function automatic logic [bdss_pkg::NameW-1:0] random_name();
        logic [bdss_pkg::NameW-1:0] raw;
        int                         len;
        bit                         junk;
        len  = $urandom_range(0, bdss_pkg::NameW / 8);
        junk = 1'($urandom_range(0, 1));
        for (int k = 0; k < bdss_pkg::NameW / 8; k++)
        begin
            raw[k*8 +: 8] = 8'($urandom);
            if (k == len || (k > len && !junk))
            begin
                raw[k*8 +: 8] = 8'h00;
            end
        end
        return raw;
    endfunction

    function automatic outcome_t make_outcome(logic [2:0] st, logic [bdss_pkg::NameW-1:0] nm,
                                              logic [bdss_pkg::PriceW-1:0] pr, logic last);
        outcome_t o;
        o.status = st;
        o.name   = nm;
        o.price  = pr;
        o.count  = held[bdss_pkg::CountW-1:0];
        o.total  = price_sum;
        o.last   = last;
        return o;
    endfunction

    // Applies one accepted request to the predicted list and queues its results.
    // Returns the status of the first result so that the table can spot-check it.
    function automatic logic [2:0] predict_request(logic [2:0] req,
                                                   logic [bdss_pkg::NameW-1:0] raw,
                                                   logic [bdss_pkg::PriceW-1:0] pr);
        logic [bdss_pkg::NameW-1:0]  key;
        logic [bdss_pkg::NameW-1:0]  tmp_name;
        logic [bdss_pkg::PriceW-1:0] tmp_price;
        int                          hits;
        key = trim_name(raw);
        case (req)
            bdss_pkg::REQ_PUSH_FRONT, bdss_pkg::REQ_PUSH_BACK:
            begin
                if (held >= Depth)
                begin
                    pending_results.push_back(make_outcome(bdss_pkg::ST_FULL, '0, '0, 1'b1));
                    return bdss_pkg::ST_FULL;
                end
                if (req == bdss_pkg::REQ_PUSH_FRONT)
                begin
                    for (int k = held; k > 0; k--)
                    begin
                        list_name[k]  = list_name[k-1];
                        list_price[k] = list_price[k-1];
                    end
                    list_name[0]  = key;
                    list_price[0] = pr;
                end
                else
                begin
                    list_name[held]  = key;
                    list_price[held] = pr;
                end
                held++;
                price_sum = price_sum + bdss_pkg::TotalW'(pr);
                pending_results.push_back(make_outcome(bdss_pkg::ST_OK, key, pr, 1'b1));
                return bdss_pkg::ST_OK;
            end
            bdss_pkg::REQ_POP_FRONT, bdss_pkg::REQ_POP_BACK:
            begin
                if (held == 0)
                begin
                    pending_results.push_back(make_outcome(bdss_pkg::ST_EMPTY, '0, '0, 1'b1));
                    return bdss_pkg::ST_EMPTY;
                end
                if (req == bdss_pkg::REQ_POP_FRONT)
                begin
                    tmp_name  = list_name[0];
                    tmp_price = list_price[0];
                    for (int k = 0; k < held - 1; k++)
                    begin
                        list_name[k]  = list_name[k+1];
                        list_price[k] = list_price[k+1];
                    end
                end
                else
                begin
                    tmp_name  = list_name[held-1];
                    tmp_price = list_price[held-1];
                end
                held--;
                price_sum = price_sum - bdss_pkg::TotalW'(tmp_price);
                pending_results.push_back(
                    make_outcome(bdss_pkg::ST_OK, tmp_name, tmp_price, 1'b1));
                return bdss_pkg::ST_OK;
            end
            bdss_pkg::REQ_FIND_NAME, bdss_pkg::REQ_FIND_PRICE:
            begin
                hits = 0;
                for (int k = 0; k < held; k++)
                begin
                    if ((req == bdss_pkg::REQ_FIND_NAME) ? (list_name[k] == key)
                                                         : (list_price[k] == pr))
                    begin
                        pending_results.push_back(
                            make_outcome(bdss_pkg::ST_OK, list_name[k], list_price[k], 1'b0));
                        hits++;
                    end
                end
                if (hits == 0)
                begin
                    pending_results.push_back(
                        make_outcome(bdss_pkg::ST_NOT_FOUND, '0, '0, 1'b1));
                    return bdss_pkg::ST_NOT_FOUND;
                end
                pending_results[pending_results.size() - 1].last = 1'b1;
                return bdss_pkg::ST_OK;
            end
            bdss_pkg::REQ_SORT:
            begin
                if (held < 2)
                begin
                    pending_results.push_back(
                        make_outcome(bdss_pkg::ST_TOO_FEW, '0, '0, 1'b1));
                    return bdss_pkg::ST_TOO_FEW;
                end
                // Exchange sort: each position against every later one.
                for (int i = 0; i < held; i++)
                begin
                    for (int j = i + 1; j < held; j++)
                    begin
                        if (list_price[i] > list_price[j])
                        begin
                            tmp_name      = list_name[i];
                            tmp_price     = list_price[i];
                            list_name[i]  = list_name[j];
                            list_price[i] = list_price[j];
                            list_name[j]  = tmp_name;
                            list_price[j] = tmp_price;
                        end
                    end
                end
                for (int k = 0; k < held; k++)
                begin
                    pending_results.push_back(
                        make_outcome(bdss_pkg::ST_OK, list_name[k], list_price[k],
                                     k == held - 1));
                end
                return bdss_pkg::ST_OK;
            end
            default:
            begin
                // The unused request code is dropped without a result.
                return bdss_pkg::ST_OK;
            end
        endcase
    endfunction

    // Presents one item and waits for its acceptance. The valid stays high across
    // back-to-back items so that it is never lowered and raised in the same step.
    task automatic send_request(logic [2:0] req, logic [bdss_pkg::NameW-1:0] nm,
                                logic [bdss_pkg::PriceW-1:0] pr,
                                output logic [2:0] first_status);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {pr, nm};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        first_status = predict_request(req, nm, pr);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic void add_row(logic [2:0] req, logic [bdss_pkg::NameW-1:0] nm,
                                    logic [bdss_pkg::PriceW-1:0] pr, bit fixed,
                                    logic [2:0] st);
        row_t r;
        r.req    = req;
        r.name   = nm;
        r.price  = pr;
        r.fixed  = fixed;
        r.status = st;
        table_rows.push_back(r);
    endfunction

    // Result side: random stalls per item, and every accepted item checked in order.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result item status=%0d data=%h", $time,
                         m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[151:0] !== want.name)
                begin
                    $display("%0t: name expected %h actual %h", $time, want.name,
                             m_axis_tdata[151:0]);
                    errors++;
                end
                if (m_axis_tdata[167:152] !== want.price)
                begin
                    $display("%0t: price expected %h actual %h", $time, want.price,
                             m_axis_tdata[167:152]);
                    errors++;
                end
                if (m_axis_tdata[172:168] !== want.count)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, want.count,
                             m_axis_tdata[172:168]);
                    errors++;
                end
                if (m_axis_tdata[192:173] !== want.total)
                begin
                    $display("%0t: total expected %h actual %h", $time, want.total,
                             m_axis_tdata[192:173]);
                    errors++;
                end
                if (m_axis_tdata[199:193] !== 7'd0)
                begin
                    $display("%0t: pad expected 0 actual %h", $time, m_axis_tdata[199:193]);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, want.last,
                             m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, then the final verdict.
    initial
    begin
        logic [2:0]                  got;
        logic [2:0]                  req;
        logic [bdss_pkg::NameW-1:0]  nm;
        logic [bdss_pkg::PriceW-1:0] pr;
        int                          mode;
        int                          pick;
        int                          wait_cycles;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        errors        = 0;
        no_idle       = 1'b0;
        held          = 0;
        price_sum     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list cases first, then extremes of name and price.
        add_row(bdss_pkg::REQ_FIND_NAME, '0, '0, 1, bdss_pkg::ST_NOT_FOUND);
        add_row(bdss_pkg::REQ_FIND_PRICE, '0, '0, 1, bdss_pkg::ST_NOT_FOUND);
        add_row(bdss_pkg::REQ_POP_FRONT, '0, '0, 1, bdss_pkg::ST_EMPTY);
        add_row(bdss_pkg::REQ_POP_BACK, '0, '0, 1, bdss_pkg::ST_EMPTY);
        add_row(bdss_pkg::REQ_SORT, '0, '0, 1, bdss_pkg::ST_TOO_FEW);
        add_row(REQ_UNUSED, '1, '1, 0, bdss_pkg::ST_OK);
        add_row(bdss_pkg::REQ_PUSH_BACK, '1, 16'hFFFF, 1, bdss_pkg::ST_OK);
        add_row(bdss_pkg::REQ_SORT, '0, '0, 1, bdss_pkg::ST_TOO_FEW);
        add_row(bdss_pkg::REQ_PUSH_FRONT, '0, '0, 1, bdss_pkg::ST_OK);
        // A short name with junk after its terminator; found again by its clean form.
        add_row(bdss_pkg::REQ_PUSH_BACK, {{17{8'hA5}}, 8'h00, 8'h41}, 16'h1234, 1,
                bdss_pkg::ST_OK);
        add_row(bdss_pkg::REQ_FIND_NAME, {{17{8'h00}}, 8'h00, 8'h41}, '0, 0, bdss_pkg::ST_OK);
        add_row(bdss_pkg::REQ_FIND_NAME, {{17{8'h5A}}, 8'h00, 8'h41}, '0, 0, bdss_pkg::ST_OK);
        add_row(bdss_pkg::REQ_FIND_PRICE, '0, 16'hFFFF, 0, bdss_pkg::ST_OK);
        add_row(bdss_pkg::REQ_PUSH_FRONT, {8'h00, {18{8'h7E}}}, 16'h0001, 1, bdss_pkg::ST_OK);
        add_row(bdss_pkg::REQ_FIND_PRICE, '0, 16'h7777, 1, bdss_pkg::ST_NOT_FOUND);
        add_row(bdss_pkg::REQ_SORT, '0, '0, 0, bdss_pkg::ST_OK);
        add_row(bdss_pkg::REQ_POP_FRONT, '0, '0, 0, bdss_pkg::ST_OK);
        add_row(bdss_pkg::REQ_POP_BACK, '0, '0, 0, bdss_pkg::ST_OK);
        add_row(REQ_UNUSED, '0, '0, 0, bdss_pkg::ST_OK);
        foreach (table_rows[r])
        begin
            send_request(table_rows[r].req, table_rows[r].name, table_rows[r].price, got);
            if (table_rows[r].fixed && got !== table_rows[r].status)
            begin
                $display("%0t: row %0d status expected %0d actual %0d", $time, r,
                         table_rows[r].status, got);
                errors++;
            end
        end

        // A small pool of names and prices makes finds hit and sorts see ties.
        foreach (name_pool[k])
        begin
            name_pool[k] = random_name();
        end
        foreach (price_pool[k])
        begin
            price_pool[k] = 16'($urandom);
        end

        // Random part in phases: growing, shrinking and mixed, some without idling.
        for (int n = 0; n < 380; n++)
        begin
            if (n % 40 == 0)
            begin
                mode    = $urandom_range(0, 2);
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n == 190)
            begin
                // Hold off until the block has handed out everything it owes.
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                req = $urandom_range(0, 1) ? bdss_pkg::REQ_FIND_NAME : bdss_pkg::REQ_FIND_PRICE;
            end
            else if (pick < 18)
            begin
                req = bdss_pkg::REQ_SORT;
            end
            else if (pick < 20)
            begin
                req = REQ_UNUSED;
            end
            else if ((mode == 0 && pick < 80) || (mode == 1 && pick < 35)
                     || (mode == 2 && pick < 60))
            begin
                req = $urandom_range(0, 1) ? bdss_pkg::REQ_PUSH_FRONT : bdss_pkg::REQ_PUSH_BACK;
            end
            else
            begin
                req = $urandom_range(0, 1) ? bdss_pkg::REQ_POP_FRONT : bdss_pkg::REQ_POP_BACK;
            end
            nm = ($urandom_range(0, 2) == 0) ? random_name()
                                             : name_pool[$urandom_range(0, 5)];
            pr = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                             : price_pool[$urandom_range(0, 4)];
            send_request(req, nm, pr, got);
        end

        drain_results();
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (Latency) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("tb_bounded_deque_search_sort: PASS");
        end
        else
        begin
            if (pending_results.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived", $time,
                         pending_results.size());
            end
            $display("tb_bounded_deque_search_sort: FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("tb_bounded_deque_search_sort: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/bdss_pkg.sv
hw/rtl/bdss_ctrl.sv
hw/rtl/bdss_dp.sv
hw/rtl/bounded_deque_search_sort.sv
hw/rtl/bdss_checker.sv
bench/tb_bounded_deque_search_sort.sv
